// File: sv/chb_pkg.sv
// Shared types and constants for the chained hash table.
// Used by the top level, the checker and the testbench; no dependencies of its own.
package chb_pkg;

  localparam int KEY_BITS         = 31;
  localparam int MAX_BUCKETS      = 16;
  localparam int SLOTS_PER_BUCKET = 8;
  localparam int CFG_BITS         = 5;
  localparam int BUCKET_BITS      = 4;
  localparam int CFG_RESET        = 16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } chb_op_t;

  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } chb_status_t;

  typedef struct packed {
    chb_op_t               op;
    logic [KEY_BITS-1:0]   key;
  } chb_in_t;

  typedef struct packed {
    chb_status_t             status;
    logic [BUCKET_BITS-1:0]  bucket;
  } chb_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_LOOKUP,
    S_SCAN,
    S_RESULT
  } chb_state_t;

endpackage

// File: sv/chained_hash_table.sv
// Top level of the chained hash table: control sequencer, fill counts, key store.
// Depends on chb_pkg, chb_mod and chb_ram.
//
//   channel | ports                          | handshake
//   --------+--------------------------------+----------------------------
//   request | in_valid in_ready in_data      | valid/ready
//   result  | out_valid out_ready out_data   | valid/ready, output register
//   config  | cfg_we cfg_wdata               | write on cfg_we, no wait
//
// An item runs through the serial remainder unit, one key bit per cycle, and a
// search then reads the key store once per chain slot until a hit or the last
// filled slot; a new request is taken only when the sequencer is idle again.
// Synchronous reset clears fill counts and control; no clearing pass.
// A waiting result does not block the next request from being accepted.
module chained_hash_table #(
  parameter int MAX_BUCKETS      = chb_pkg::MAX_BUCKETS,
  parameter int SLOTS_PER_BUCKET = chb_pkg::SLOTS_PER_BUCKET
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  chb_pkg::chb_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output chb_pkg::chb_out_t              out_data,
  input  logic                           cfg_we,
  input  logic [chb_pkg::CFG_BITS-1:0]   cfg_wdata
);

  localparam int KEY_W  = chb_pkg::KEY_BITS;
  localparam int CFG_W  = chb_pkg::CFG_BITS;
  localparam int OUT_BW = chb_pkg::BUCKET_BITS;
  localparam int DIV_W  = $clog2(MAX_BUCKETS + 1);
  localparam int BKT_W  = MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1;
  localparam int SLOT_W = SLOTS_PER_BUCKET > 1 ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int FILL_W = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int DEPTH  = MAX_BUCKETS * SLOTS_PER_BUCKET;
  localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;

  chb_pkg::chb_state_t  state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r;
  logic [DIV_W-1:0]     div_in;
  chb_pkg::chb_op_t     op_r;
  logic [KEY_W-1:0]     key_r;
  logic [BKT_W-1:0]     bkt_r;
  logic [SLOT_W-1:0]    j_r;
  chb_pkg::chb_status_t stat_r;
  logic [FILL_W-1:0]    fill_r [MAX_BUCKETS];
  logic                 out_valid_r;
  chb_pkg::chb_out_t    out_data_r;

  logic                 accept;
  logic                 mod_done;
  logic [DIV_W-1:0]     mod_rem;
  logic [FILL_W-1:0]    fill_cur;
  logic                 is_full;
  logic                 hit;
  logic                 last;
  logic                 out_free;
  logic                 ram_we;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [SLOT_W-1:0]    rd_j;
  logic [KEY_W-1:0]     ram_rdata;
  logic [ADDR_W-1:0]    bkt_base;

  // clamp the configured count into 1..MAX_BUCKETS
  always_comb begin
    if (cfg_r == '0) begin
      div_in = DIV_W'(1);
    end else if (cfg_r > CFG_W'(MAX_BUCKETS)) begin
      div_in = DIV_W'(MAX_BUCKETS);
    end else begin
      div_in = DIV_W'(cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_W'(chb_pkg::CFG_RESET);
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  assign accept   = in_valid && in_ready;
  assign fill_cur = fill_r[bkt_r];
  assign is_full  = fill_cur == FILL_W'(SLOTS_PER_BUCKET);
  assign hit      = ram_rdata == key_r;
  assign last     = (FILL_W'(j_r) + FILL_W'(1)) == fill_cur;
  assign out_free = !out_valid_r || out_ready;
  assign bkt_base = ADDR_W'(ADDR_W'(bkt_r) * ADDR_W'(SLOTS_PER_BUCKET));

  chb_mod #(
    .KEY_W (KEY_W),
    .DIV_W (DIV_W)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (accept),
    .key     (in_data.key),
    .divisor (div_in),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  chb_ram #(
    .WIDTH (KEY_W),
    .DEPTH (DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chb_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = chb_pkg::S_DIV;
        end
      end
      chb_pkg::S_DIV: begin
        if (mod_done) begin
          state_nxt = chb_pkg::S_LOOKUP;
        end
      end
      chb_pkg::S_LOOKUP: begin
        if (op_r == chb_pkg::OP_SEARCH && fill_cur != '0) begin
          state_nxt = chb_pkg::S_SCAN;
        end else begin
          state_nxt = chb_pkg::S_RESULT;
        end
      end
      chb_pkg::S_SCAN: begin
        if (hit || last) begin
          state_nxt = chb_pkg::S_RESULT;
        end
      end
      chb_pkg::S_RESULT: begin
        if (out_free) begin
          state_nxt = chb_pkg::S_IDLE;
        end
      end
      default: state_nxt = chb_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rd_j      = '0;
    ram_waddr = bkt_base + ADDR_W'(fill_cur);
    unique case (state_r)
      chb_pkg::S_IDLE: begin
        in_ready = 1'b1;
      end
      chb_pkg::S_LOOKUP: begin
        if (op_r == chb_pkg::OP_INSERT) begin
          ram_we = !is_full;
        end else begin
          ram_re = fill_cur != '0;
        end
      end
      chb_pkg::S_SCAN: begin
        rd_j   = j_r + SLOT_W'(1);
        ram_re = !hit && !last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ram_raddr = bkt_base + ADDR_W'(rd_j);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= chb_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == chb_pkg::S_RESULT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BUCKETS; i++) begin
        fill_r[i] <= '0;
      end
    end else if (ram_we) begin
      fill_r[bkt_r] <= fill_cur + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_data.op;
      key_r <= in_data.key;
    end
    if (state_r == chb_pkg::S_DIV && mod_done) begin
      bkt_r <= BKT_W'(mod_rem);
    end
    if (ram_re) begin
      j_r <= rd_j;
    end
    unique case (state_r)
      chb_pkg::S_LOOKUP: begin
        if (op_r == chb_pkg::OP_INSERT) begin
          stat_r <= is_full ? chb_pkg::STAT_FULL : chb_pkg::STAT_INSERTED;
        end else begin
          stat_r <= chb_pkg::STAT_NOT_FOUND;
        end
      end
      chb_pkg::S_SCAN: begin
        if (hit) begin
          stat_r <= chb_pkg::STAT_FOUND;
        end
      end
      default: begin
        stat_r <= stat_r;
      end
    endcase
    if (state_r == chb_pkg::S_RESULT && out_free) begin
      out_data_r.status <= stat_r;
      out_data_r.bucket <= OUT_BW'(bkt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/chb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module chb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/chb_mod.sv
// Bit-serial remainder unit: key modulo a small divisor, one key bit per cycle.
// Depends on nothing but its parameters.
module chb_mod #(
  parameter int KEY_W = 31,
  parameter int DIV_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] rem
);

  localparam int CNT_W = $clog2(KEY_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0] sr_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] div_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W:0]   shifted;

  // restoring step: bring in the next key bit, subtract once if it fits
  always_comb begin
    shifted = {rem_r, sr_r[KEY_W-1]};
    if (shifted >= {1'b0, div_r}) begin
      rem_nxt = DIV_W'(shifted - {1'b0, div_r});
    end else begin
      rem_nxt = DIV_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr_r  <= key;
      rem_r <= '0;
      cnt_r <= CNT_W'(KEY_W);
      div_r <= divisor;
    end else if (busy_r) begin
      sr_r  <= sr_r << 1;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: sv/chb_checker.sv
// Port-level checks for the chained hash table, bound to the top level.
// Depends on chb_pkg and chained_hash_table.
module chb_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input chb_pkg::chb_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the serial remainder keeps the block busy after a request
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request taken while previous one in progress");

endmodule

bind chained_hash_table chb_checker u_chb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/chained_hash_table_tb.sv
// Self-checking testbench for chained_hash_table: directed and random insert/search traffic.
// Depends on chb_pkg and the chained_hash_table RTL; predicts each result in step with acceptance.
`timescale 1ns / 100ps

module chained_hash_table_tb;

  localparam int KEY_W        = chb_pkg::KEY_BITS;
  localparam int CFG_W        = chb_pkg::CFG_BITS;
  localparam int OUT_BW       = chb_pkg::BUCKET_BITS;
  localparam int NBUCKETS     = chb_pkg::MAX_BUCKETS;
  localparam int NSLOTS       = chb_pkg::SLOTS_PER_BUCKET;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 138;
  localparam int DRAIN_CYCLES = 60;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  chb_pkg::chb_in_t     in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  chb_pkg::chb_out_t    out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predicted table contents
  logic [CFG_W-1:0]     bucket_count_q = CFG_W'(chb_pkg::CFG_RESET);
  logic [KEY_W-1:0]     chain_keys [NBUCKETS][NSLOTS];
  int unsigned          chain_fill [NBUCKETS];

  chb_pkg::chb_out_t    pending_results [$];
  logic [KEY_W-1:0]     inserted_keys [$];
  bit                   idle_on  = 1'b0;
  int                   errors   = 0;
  int                   requests = 0;
  int                   settings = 0;
  int                   status_seen [4];

  chained_hash_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic chb_pkg::chb_out_t predict_table_op(chb_pkg::chb_in_t req);
    int unsigned       divisor;
    int unsigned       b;
    int unsigned       fill;
    chb_pkg::chb_out_t res;
    divisor = (bucket_count_q == 0) ? 1 : int'(bucket_count_q);
    if (divisor > NBUCKETS) divisor = NBUCKETS;
    b = req.key % divisor;
    fill = chain_fill[b];
    res.bucket = b[OUT_BW-1:0];
    if (req.op == chb_pkg::OP_INSERT) begin
      if (fill >= NSLOTS) begin
        res.status = chb_pkg::STAT_FULL;
      end else begin
        chain_keys[b][fill] = req.key;
        chain_fill[b] = fill + 1;
        res.status = chb_pkg::STAT_INSERTED;
      end
    end else begin
      res.status = chb_pkg::STAT_NOT_FOUND;
      for (int j = 0; j < fill; j++) begin
        if (chain_keys[b][j] == req.key) begin
          res.status = chb_pkg::STAT_FOUND;
          break;
        end
      end
    end
    return res;
  endfunction

  // Drive one request; returns at the edge that accepts it.
  task automatic issue_request(chb_pkg::chb_op_t op, logic [KEY_W-1:0] key);
    chb_pkg::chb_in_t req;
    int               gap;
    req.op  = op;
    req.key = key;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), predict_table_op(req));
    if (op == chb_pkg::OP_INSERT) begin
      inserted_keys.insert(inserted_keys.size(), key);
      if (inserted_keys.size() > 256) void'(inserted_keys.pop_front());
    end
    requests++;
  endtask

  // Drop valid and hold until every predicted result has come back.
  task automatic wait_table_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_W-1:0] value);
    wait_table_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    bucket_count_q = value;
    settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_single_keys();
    issue_request(chb_pkg::OP_INSERT, '0);
    issue_request(chb_pkg::OP_SEARCH, '0);
    issue_request(chb_pkg::OP_SEARCH, 31'd16);
    issue_request(chb_pkg::OP_INSERT, '1);
    issue_request(chb_pkg::OP_SEARCH, '1);
    issue_request(chb_pkg::OP_INSERT, '0);
    issue_request(chb_pkg::OP_SEARCH, '0);
  endtask

  task automatic test_full_chain();
    // fill bucket 3 to the last slot, then overflow it
    for (int i = 0; i <= NSLOTS; i++) begin
      issue_request(chb_pkg::OP_INSERT, 31'(3 + 16 * i));
    end
    issue_request(chb_pkg::OP_SEARCH, 31'(3 + 16 * (NSLOTS - 1)));
    issue_request(chb_pkg::OP_SEARCH, 31'(3 + 16 * NSLOTS));
  endtask

  task automatic test_count_changes();
    // zero acts as one bucket; keys already placed stay where they are
    write_bucket_count(5'd0);
    issue_request(chb_pkg::OP_INSERT, 31'd5);
    issue_request(chb_pkg::OP_SEARCH, 31'd3);
    // above the bucket limit saturates
    write_bucket_count(5'd31);
    issue_request(chb_pkg::OP_SEARCH, 31'd3);
    issue_request(chb_pkg::OP_SEARCH, 31'd5);
    write_bucket_count(5'd1);
    issue_request(chb_pkg::OP_SEARCH, '1);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] count;
    logic [KEY_W-1:0] key;
    chb_pkg::chb_op_t op;
    int               pick;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: count = 5'd16;
        1: count = 5'd1;
        2: count = 5'd7;
        3: count = 5'd17;
        4: count = 5'd31;
        5: count = 5'd0;
        6: count = 5'($urandom_range(2, 15));
        7: count = 5'd16;
        8: count = 5'd3;
        default: count = 5'($urandom_range(0, 31));
      endcase
      write_bucket_count(count);
      idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45 && inserted_keys.size() != 0)
          key = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else if (pick < 65)
          key = 31'($urandom_range(0, 63));
        else if (pick < 85)
          key = 31'($urandom());
        else if (pick < 93)
          key = 31'h7FFF_FFFF - 31'($urandom_range(0, 40));
        else
          key = 31'(1) << $urandom_range(0, KEY_W - 1);
        op = ($urandom_range(0, 99) < 35) ? chb_pkg::OP_INSERT : chb_pkg::OP_SEARCH;
        issue_request(op, key);
      end
    end
    idle_on = 1'b0;
  endtask

  // result sink with random stall bursts
  initial begin : result_sink
    int stall;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 13);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    chb_pkg::chb_out_t want;
    if (rst_n && out_valid && out_ready) begin
      status_seen[out_data.status]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d bucket %0d", out_data.status, out_data.bucket);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.bucket !== want.bucket) begin
          $error("bucket: expected %0d, got %0d", want.bucket, out_data.bucket);
          errors++;
        end
      end
    end
  end

  initial begin : run_limit
    #1_500_000;
    $display("chained_hash_table regression: fail");
    $finish;
  end

  initial begin : test_sequence
    for (int b = 0; b < NBUCKETS; b++) chain_fill[b] = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_single_keys();
    test_full_chain();
    test_count_changes();
    test_random_traffic();
    wait_table_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;
    $display("Covered %0d requests under %0d bucket-count settings.", requests, settings);
    $display("Results seen: %0d inserted, %0d found, %0d not found, %0d full.",
             status_seen[chb_pkg::STAT_INSERTED], status_seen[chb_pkg::STAT_FOUND],
             status_seen[chb_pkg::STAT_NOT_FOUND], status_seen[chb_pkg::STAT_FULL]);
    if (errors == 0) begin
      $display("chained_hash_table regression: pass");
    end else begin
      $display("chained_hash_table regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
sv/chb_pkg.sv
sv/chb_ram.sv
sv/chb_mod.sv
sv/chained_hash_table.sv
sv/chb_checker.sv
tb/sv/chained_hash_table_tb.sv
